@@ sv/smdf_pkg.sv @@
// ----------------------------------------------------------------------------
// smdf_pkg
// Shared types, register codes and arithmetic constants of the sparse
// multi-tap delay filter.
// ----------------------------------------------------------------------------
package smdf_pkg;

  localparam int TAP_COUNT   = 16;
  localparam int TAP_BITS    = $clog2(TAP_COUNT);
  localparam int SAMPLE_BITS = 16;
  localparam int DELAY_DEPTH = 65536;
  localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
  localparam int SPACE_BITS  = 12;
  localparam int COEF_BITS   = 8;
  localparam int WEIGHT_BITS = 9;
  localparam int H_BITS      = 16;
  localparam int PROD_BITS   = H_BITS + SAMPLE_BITS;
  localparam int ACC_BITS    = PROD_BITS + TAP_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = WEIGHT_BITS'(256);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOPOLOGY  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MORPH     = 3'd4;

  // scaling by 1/25600 = (1/1024) * (1/25), rounded half away from zero
  localparam int MAG_BITS    = ACC_BITS;
  localparam logic [MAG_BITS-1:0] ROUND_BIAS   = MAG_BITS'(12800);
  localparam logic [MAG_BITS-1:0] CLIP_POS_LIM = MAG_BITS'(32768 * 25600);
  localparam logic [MAG_BITS-1:0] CLIP_NEG_LIM = MAG_BITS'(32769 * 25600);
  localparam int QIN_BITS    = 20;
  localparam int QIN_LSB     = 10;
  localparam int RECIP_BITS  = 21;
  localparam logic [RECIP_BITS-1:0] RECIP_K = RECIP_BITS'(1342178);
  localparam int RECIP_SHIFT = 25;
  localparam int QPROD_BITS  = QIN_BITS + RECIP_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [WEIGHT_BITS-1:0]        morph_weight;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } out_t;

  function automatic logic signed [COEF_BITS-1:0] coef_of(
    input logic [CFG_DATA_BITS-1:0] lo,
    input logic [CFG_DATA_BITS-1:0] hi,
    input logic [TAP_BITS-1:0]      idx
  );
    logic [CFG_DATA_BITS-1:0] word;
    word = idx[TAP_BITS-1] ? hi : lo;
    return word[{idx[TAP_BITS-2:0], 3'b000} +: COEF_BITS];
  endfunction

endpackage

@@ sv/sparse_multitap_delay_filter_core.sv @@
// ----------------------------------------------------------------------------
// sparse_multitap_delay_filter_core
// Sixteen-tap filter over a ring delay line with spaced taps, feedforward or
// recursive, with optional crossfade of each tap against its mirror.
// ----------------------------------------------------------------------------
// One sample is taken at a time, and the next is taken only once its result
// has been loaded into the output register: the delay memory has a single read
// port, so the sixteen taps are fetched one per cycle, followed by the drain of
// the multiply and accumulate pipeline, the divide-and-saturate unit and the
// output register. A stalled result beat keeps the next result waiting in the
// finish state, and no new sample is taken meanwhile. After reset the block
// zeroes all 65536 entries of the delay memory, one entry per cycle, and holds
// in_ready low meanwhile; configuration writes are taken during that time.
module sparse_multitap_delay_filter_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  smdf_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output smdf_pkg::out_t                        out_data,
  input  logic                                  cfg_write_en,
  input  logic [smdf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [smdf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import smdf_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                   state;
  logic [CFG_DATA_BITS-1:0]     coef_low, coef_high;
  logic [SPACE_BITS-1:0]        spacing;
  logic                         topology;
  logic                         morph;
  logic [ADDR_BITS-1:0]         write_position;
  logic [ADDR_BITS-1:0]         ptr;
  logic [ADDR_BITS-1:0]         clear_addr;
  logic [ADDR_BITS-1:0]         tap_offset;
  logic [TAP_BITS-1:0]          cnt;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [WEIGHT_BITS-1:0]       w;

  logic signed [H_BITS-1:0]     h_s1;
  logic                         tap0_s1, s1_valid;
  logic signed [PROD_BITS-1:0]  prod_s2;
  logic                         s2_valid;
  logic signed [ACC_BITS-1:0]   acc;

  logic [SAMPLE_BITS-1:0]       mem [DELAY_DEPTH];
  logic [SAMPLE_BITS-1:0]       rdata;

  logic [ADDR_BITS-1:0]         len;
  logic [ADDR_BITS-1:0]         ptr_cur;
  logic [ADDR_BITS-1:0]         raddr;
  logic [ADDR_BITS:0]           ptr_inc;
  logic                         accept;
  logic                         fire;
  logic                         scale_go;
  logic                         scale_done;
  out_t                         scale_res;
  logic [WEIGHT_BITS-1:0]       w_in;
  logic signed [COEF_BITS-1:0]  c_own, c_mir;
  logic signed [WEIGHT_BITS:0]  w_own, w_mir;
  logic signed [H_BITS-1:0]     h_now;
  logic signed [SAMPLE_BITS-1:0] tap_val;

  always_comb begin
    len      = {spacing, 4'b0000} + ADDR_BITS'(1);
    ptr_cur  = (write_position >= len) ? '0 : write_position;
    raddr    = (ptr >= tap_offset) ? ptr - tap_offset
                                   : ADDR_BITS'({1'b0, ptr} + {1'b0, len}
                                                - {1'b0, tap_offset});
    ptr_inc  = {1'b0, ptr} + (ADDR_BITS+1)'(1);
    accept   = in_valid && in_ready;
    fire     = (state == ST_FINISH) && (!out_valid || out_ready);
    scale_go = (state == ST_DRAIN) && !s1_valid && !s2_valid;
    w_in     = (in_data.morph_weight > WEIGHT_FULL) ? WEIGHT_FULL : in_data.morph_weight;
    c_own    = coef_of(coef_low, coef_high, cnt);
    c_mir    = coef_of(coef_low, coef_high, TAP_BITS'(TAP_COUNT - 1) - cnt);
    w_own    = morph ? $signed({1'b0, WEIGHT_FULL - w}) : $signed({1'b0, WEIGHT_FULL});
    w_mir    = morph ? $signed({1'b0, w}) : '0;
    h_now    = H_BITS'(c_own * w_own + c_mir * w_mir);
    tap_val  = tap0_s1 ? x : $signed(rdata);
  end

  assign in_ready = (state == ST_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clear_addr     <= '0;
      coef_low       <= CFG_DATA_BITS'(100);
      coef_high      <= '0;
      spacing        <= SPACE_BITS'(1);
      topology       <= 1'b0;
      morph          <= 1'b0;
      write_position <= '0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_COEF_LOW:  coef_low  <= cfg_data;
          REG_COEF_HIGH: coef_high <= cfg_data;
          REG_SPACING: begin
            spacing        <= cfg_data[SPACE_BITS-1:0];
            write_position <= '0;
          end
          REG_TOPOLOGY:  topology  <= cfg_data[0];
          REG_MORPH:     morph     <= cfg_data[0];
          default: ;
        endcase
      end
      s1_valid <= (state == ST_RUN);
      s2_valid <= s1_valid;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + ADDR_BITS'(1);
          if (clear_addr == ADDR_BITS'(DELAY_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt <= cnt + TAP_BITS'(1);
          if (cnt == TAP_BITS'(TAP_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (scale_go) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scale_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            write_position <= (ptr_inc[ADDR_BITS-1:0] == len && !ptr_inc[ADDR_BITS])
                              ? '0 : ptr_inc[ADDR_BITS-1:0];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // tap datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      x          <= in_data.sample_in;
      w          <= w_in;
      ptr        <= ptr_cur;
      tap_offset <= '0;
      acc        <= '0;
    end else begin
      if (state == ST_RUN) begin
        tap_offset <= tap_offset + ADDR_BITS'(spacing);
      end
      if (s2_valid) begin
        acc <= acc + ACC_BITS'(prod_s2);
      end
    end
    h_s1    <= h_now;
    tap0_s1 <= (cnt == '0);
    prod_s2 <= PROD_BITS'(h_s1 * tap_val);
    if (fire) begin
      out_data <= scale_res;
    end
  end

  // delay memory
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clear_addr] <= '0;
    end else if (accept && topology) begin
      mem[ptr_cur] <= in_data.sample_in;
    end else if (fire && !topology) begin
      mem[ptr] <= scale_res.sample_out;
    end
    rdata <= mem[raddr];
  end

  smdf_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .go     (scale_go),
    .acc    (acc),
    .done   (scale_done),
    .result (scale_res)
  );

endmodule

@@ sv/smdf_scale.sv @@
// ----------------------------------------------------------------------------
// smdf_scale
// Three-stage divide by 25600 with rounding and saturation of the
// accumulated sum of products.
// ----------------------------------------------------------------------------
module smdf_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic signed [smdf_pkg::ACC_BITS-1:0] acc,
  output logic                              done,
  output smdf_pkg::out_t                    result
);
  import smdf_pkg::*;

  logic                    v1, v2;
  logic                    neg1, clip1, neg2, clip2;
  logic [QIN_BITS-1:0]     m1;
  logic [QPROD_BITS-1:0]   prod2;

  logic                    neg;
  logic [MAG_BITS-1:0]     mag;
  logic [MAG_BITS-1:0]     num;
  logic                    clip;
  logic [SAMPLE_BITS-1:0]  quo;

  always_comb begin
    neg  = acc[ACC_BITS-1];
    mag  = neg ? MAG_BITS'(-acc) : MAG_BITS'(acc);
    num  = mag + ROUND_BIAS;
    clip = neg ? (num >= CLIP_NEG_LIM) : (num >= CLIP_POS_LIM);
    quo  = prod2[RECIP_SHIFT +: SAMPLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    neg1  <= neg;
    clip1 <= clip;
    m1    <= num[QIN_LSB +: QIN_BITS];
    neg2  <= neg1;
    clip2 <= clip1;
    prod2 <= QPROD_BITS'(m1) * QPROD_BITS'(RECIP_K);
    if (v2) begin
      result.clipped <= clip2;
      if (clip2) begin
        result.sample_out <= neg2 ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
        result.sample_out <= neg2 ? -$signed(quo) : $signed(quo);
      end
    end
  end

endmodule

@@ sv/smdf_checker.sv @@
// ----------------------------------------------------------------------------
// smdf_checker
// Port-level checks of the sparse multi-tap delay filter, bound to the top.
// ----------------------------------------------------------------------------
module smdf_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input smdf_pkg::out_t out_data
);
  import smdf_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // delay memory clearing follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing");

  // one sample in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

  // saturation flag comes with a rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |->
      out_data.sample_out == SAMPLE_MAX || out_data.sample_out == SAMPLE_MIN)
    else $error("clipped beat not at a rail");

endmodule

bind sparse_multitap_delay_filter_core smdf_checker u_smdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
